// ----- rtl/tos_pkg.sv -----
// Shared types and constants of the target offset smoother.
// Used by tos_front, tos_back and the top level; depends on nothing else.
package tos_pkg;

	localparam int BOX_W       = 16;
	localparam int ALPHA_W     = 16;
	localparam int OUT_W       = 11;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam int THOUSAND  = 1000;
	localparam int OUT_LIMIT = 1000;

	localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_BASE  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ORIENTATION = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MIRRORED    = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION   = 3'd3;

	localparam logic [1:0] ORIENT_0   = 2'd0;
	localparam logic [1:0] ORIENT_90  = 2'd1;
	localparam logic [1:0] ORIENT_180 = 2'd2;
	localparam logic [1:0] ORIENT_270 = 2'd3;

	localparam logic [2:0] DIR_NONE  = 3'd0;
	localparam logic [2:0] DIR_FRONT = 3'd1;
	localparam logic [2:0] DIR_BACK  = 3'd2;
	localparam logic [2:0] DIR_DOWN  = 3'd3;
	localparam logic [2:0] DIR_UP    = 3'd4;

	localparam logic [ALPHA_W-1:0] ALPHA_BASE_RESET = 16'd19661;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha_base;
		logic [1:0]         orientation;
		logic               mirrored;
		logic [2:0]         direction;
	} cfg_t;

endpackage

// ----- rtl/tos_fifo.sv -----
// Short queue between the front and back parts of the smoother.
// Generic register-based FIFO; no package dependencies.
module tos_fifo #(
	parameter int WIDTH = 41,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNW-1:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/tos_front.sv -----
// Front part: takes boxes, forms the centre offsets and drops boxes for an unmounted camera.
// Depends on tos_pkg for field widths and direction codes.
module tos_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tos_pkg::BOX_W-1:0]     box_left,
	input  logic [tos_pkg::BOX_W-1:0]     box_top,
	input  logic [tos_pkg::BOX_W-1:0]     box_width,
	input  logic [tos_pkg::BOX_W-1:0]     box_height,
	input  logic                          skip_report,
	input  logic [2:0]                    direction,
	input  logic                          q_full,
	output logic                          q_push,
	output logic signed [FRAC_BITS+3:0]   raw_x,
	output logic signed [FRAC_BITS+3:0]   raw_y,
	output logic                          raw_skip
);

	localparam int SW = FRAC_BITS + 4;
	localparam int CW = (SW > 20) ? SW : 20;
	localparam logic signed [CW-1:0] SAT_HI = CW'((64'sd1 <<< (FRAC_BITS + 3)) - 64'sd1);
	localparam logic signed [CW-1:0] SAT_LO = -SAT_HI - CW'(1);

	logic [tos_pkg::BOX_W-1:0] box_pos [2];
	logic [tos_pkg::BOX_W-1:0] box_size [2];
	logic signed [SW-1:0]      raw [2];
	logic                      dir_active;

	assign box_pos[0]  = box_left;
	assign box_pos[1]  = box_top;
	assign box_size[0] = box_width;
	assign box_size[1] = box_height;

	// Centre minus one half, in Q.17: twice the edge plus the size, minus one half.
	for (genvar a = 0; a < 2; a++) begin : g_axis
		logic signed [19:0]   c17;
		logic signed [CW-1:0] cf;

		assign c17 = $signed({3'b000, box_pos[a], 1'b0}) + $signed({4'b0000, box_size[a]})
			- 20'sd65536;

		if (FRAC_BITS >= 17) begin : g_up
			assign cf = CW'(c17) <<< (FRAC_BITS - 17);
		end else begin : g_down
			localparam logic signed [19:0] HALF = 20'(1 << (16 - FRAC_BITS));
			logic signed [19:0] biased;
			assign biased = c17 + HALF;
			assign cf     = CW'(biased >>> (17 - FRAC_BITS));
		end

		always_comb begin
			if (cf > SAT_HI) begin
				raw[a] = SAT_HI[SW-1:0];
			end else if (cf < SAT_LO) begin
				raw[a] = SAT_LO[SW-1:0];
			end else begin
				raw[a] = cf[SW-1:0];
			end
		end
	end

	assign dir_active = (direction == tos_pkg::DIR_FRONT) || (direction == tos_pkg::DIR_BACK)
		|| (direction == tos_pkg::DIR_DOWN) || (direction == tos_pkg::DIR_UP);

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full && dir_active;
	assign raw_x    = raw[0];
	assign raw_y    = raw[1];
	assign raw_skip = skip_report;

endmodule

// ----- rtl/tos_back.sv -----
// Back part: adaptive smoother update, then rotation, scaling to thousandths and the output register.
// Depends on tos_pkg for the configuration struct, codes and output width.
module tos_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tos_pkg::cfg_t                       cfg,
	input  logic                                q_empty,
	input  logic signed [FRAC_BITS+3:0]         q_raw_x,
	input  logic signed [FRAC_BITS+3:0]         q_raw_y,
	input  logic                                q_skip,
	output logic                                q_pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tos_pkg::OUT_W-1:0]    offset_horizontal,
	output logic signed [tos_pkg::OUT_W-1:0]    offset_vertical
);

	localparam int SW  = FRAC_BITS + 4;
	localparam int EW  = SW + 1;
	localparam int AW  = FRAC_BITS + 5;
	localparam int PW  = 2 * FRAC_BITS + 6;
	localparam int RW  = PW - FRAC_BITS;
	localparam int UW  = FRAC_BITS + 7;
	localparam int MW  = SW + 10;
	localparam int QW  = MW - FRAC_BITS;
	localparam int ONE = 1 << FRAC_BITS;
	localparam logic [AW-1:0] ALPHA_LO = AW'((ONE + 5) / 10);
	localparam logic [AW-1:0] ALPHA_HI = AW'((8 * ONE + 5) / 10);
	localparam logic signed [PW-1:0] RND_HALF = PW'(64'sd1 <<< (FRAC_BITS - 1));
	localparam logic [MW-1:0] MILLI_HALF = MW'(64'd1 << (FRAC_BITS - 1));
	localparam logic signed [UW-1:0] SAT_HI = UW'((64'sd1 <<< (FRAC_BITS + 3)) - 64'sd1);
	localparam logic signed [UW-1:0] SAT_LO = -SAT_HI - UW'(1);

	logic                 loaded_q;
	logic signed [SW-1:0] smooth_x_q;
	logic signed [SW-1:0] smooth_y_q;
	logic                 valid_s1;
	logic                 skip_s1;
	logic                 valid_s2;
	logic signed [tos_pkg::OUT_W-1:0] hor_s2;
	logic signed [tos_pkg::OUT_W-1:0] ver_s2;

	logic                 s1_free;
	logic                 s2_free;
	logic [AW-1:0]        alpha_base_f;
	logic signed [SW-1:0] next_x;
	logic signed [SW-1:0] next_y;
	logic [FRAC_BITS-1:0] alpha;
	logic signed [EW-1:0] err [2];
	logic [SW-1:0]        err_mag [2];
	logic signed [SW-1:0] raw_v [2];
	logic signed [SW-1:0] old_v [2];
	logic signed [SW-1:0] upd_v [2];
	logic [SW-1:0]        mag_max;
	logic [AW-1:0]        alpha_sum;

	logic signed [SW-1:0] src_h;
	logic signed [SW-1:0] src_v;
	logic                 neg_h;
	logic                 neg_v;
	logic                 is_back;
	logic                 is_down;

	function automatic logic signed [tos_pkg::OUT_W-1:0] to_milli(
		input logic signed [SW-1:0] d,
		input logic                 neg
	);
		logic [SW-1:0]              mag;
		logic [MW-1:0]              prod;
		logic [MW-1:0]              biased;
		logic [QW-1:0]              quo;
		logic [tos_pkg::OUT_W-1:0]  lim;
		mag    = d[SW-1] ? SW'(-d) : SW'(d);
		prod   = MW'(mag) * MW'(tos_pkg::THOUSAND);
		biased = prod + MILLI_HALF;
		quo    = biased[MW-1:FRAC_BITS];
		lim    = (quo > QW'(tos_pkg::OUT_LIMIT)) ? tos_pkg::OUT_W'(tos_pkg::OUT_LIMIT)
			: quo[tos_pkg::OUT_W-1:0];
		return (d[SW-1] ^ neg) ? -$signed(lim) : $signed(lim);
	endfunction

	assign s2_free = !valid_s2 || out_ready;
	assign s1_free = !valid_s1 || s2_free;
	assign q_pop   = !q_empty && s1_free;

	if (FRAC_BITS >= 16) begin : g_ab_up
		assign alpha_base_f = AW'(cfg.alpha_base) << (FRAC_BITS - 16);
	end else begin : g_ab_down
		assign alpha_base_f = AW'(cfg.alpha_base >> (16 - FRAC_BITS));
	end

	assign raw_v[0] = q_raw_x;
	assign raw_v[1] = q_raw_y;
	assign old_v[0] = smooth_x_q;
	assign old_v[1] = smooth_y_q;

	for (genvar a = 0; a < 2; a++) begin : g_err
		assign err[a]     = EW'(raw_v[a]) - EW'(old_v[a]);
		assign err_mag[a] = err[a][EW-1] ? SW'(-err[a]) : SW'(err[a]);
	end

	assign mag_max   = (err_mag[0] > err_mag[1]) ? err_mag[0] : err_mag[1];
	assign alpha_sum = alpha_base_f + AW'(mag_max >> 1);

	always_comb begin
		if (alpha_sum < ALPHA_LO) begin
			alpha = ALPHA_LO[FRAC_BITS-1:0];
		end else if (alpha_sum > ALPHA_HI) begin
			alpha = ALPHA_HI[FRAC_BITS-1:0];
		end else begin
			alpha = alpha_sum[FRAC_BITS-1:0];
		end
	end

	// Exponential update s + round(alpha * (raw - s)), saturated to the state width.
	for (genvar a = 0; a < 2; a++) begin : g_upd
		logic signed [PW-1:0] prod;
		logic signed [PW-1:0] biased;
		logic signed [RW-1:0] step;
		logic signed [UW-1:0] sum;

		assign prod   = $signed({1'b0, alpha}) * err[a];
		assign biased = prod + RND_HALF;
		assign step   = $signed(biased[PW-1:FRAC_BITS]);
		assign sum    = UW'(old_v[a]) + UW'(step);

		always_comb begin
			if (sum > SAT_HI) begin
				upd_v[a] = SAT_HI[SW-1:0];
			end else if (sum < SAT_LO) begin
				upd_v[a] = SAT_LO[SW-1:0];
			end else begin
				upd_v[a] = sum[SW-1:0];
			end
		end
	end

	assign next_x = loaded_q ? upd_v[0] : q_raw_x;
	assign next_y = loaded_q ? upd_v[1] : q_raw_y;

	// Stage 1 holds the smoother state; its latest value is the payload of the beat in stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q   <= 1'b0;
			smooth_x_q <= '0;
			smooth_y_q <= '0;
			valid_s1   <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= q_pop;
			if (q_pop) begin
				loaded_q   <= 1'b1;
				smooth_x_q <= next_x;
				smooth_y_q <= next_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			skip_s1 <= q_skip;
		end
	end

	assign is_back = (cfg.direction == tos_pkg::DIR_BACK);
	assign is_down = (cfg.direction == tos_pkg::DIR_DOWN);

	always_comb begin
		src_h = smooth_x_q;
		src_v = smooth_y_q;
		neg_h = 1'b0;
		neg_v = 1'b0;
		unique case (cfg.orientation)
			tos_pkg::ORIENT_0: begin
				src_h = smooth_x_q;
				src_v = smooth_y_q;
			end
			tos_pkg::ORIENT_90: begin
				src_h = smooth_y_q;
				src_v = smooth_x_q;
				neg_v = 1'b1;
			end
			tos_pkg::ORIENT_180: begin
				src_h = smooth_x_q;
				src_v = smooth_y_q;
				neg_h = 1'b1;
				neg_v = 1'b1;
			end
			tos_pkg::ORIENT_270: begin
				src_h = smooth_y_q;
				src_v = smooth_x_q;
				neg_h = 1'b1;
			end
			default: begin
				src_h = smooth_x_q;
				src_v = smooth_y_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1 && !skip_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			hor_s2 <= to_milli(src_h, neg_h ^ cfg.mirrored ^ is_back);
			ver_s2 <= to_milli(src_v, neg_v ^ is_back ^ !is_down);
		end
	end

	assign out_valid         = valid_s2;
	assign offset_horizontal = hor_s2;
	assign offset_vertical   = ver_s2;

endmodule

// ----- rtl/target_offset_smoother.sv -----
// Top level of the target offset smoother: configuration registers, front, queue and back.
// Depends on tos_pkg, tos_front, tos_fifo and tos_back.
//
// Channel  Direction  Handshake            Beat contents
// in       input      in_valid/in_ready    box_left, box_top, box_width, box_height, skip_report
// out      output     out_valid/out_ready  offset_horizontal, offset_vertical
// cfg      input      cfg_write            cfg_index, cfg_data
//
// One box is taken every cycle unless the queue is full; results pass queue, stage 1, stage 2.
// The smoother update loop sets the rate; the queue absorbs output stalls.
// The queue holds QUEUE_DEPTH beats; input ready drops only when it is full.
// Reset clears the smoother, the queue and all valid flags at once; no clearing pass.
module target_offset_smoother #(
	parameter int FRAC_BITS   = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [tos_pkg::BOX_W-1:0]           box_left,
	input  logic [tos_pkg::BOX_W-1:0]           box_top,
	input  logic [tos_pkg::BOX_W-1:0]           box_width,
	input  logic [tos_pkg::BOX_W-1:0]           box_height,
	input  logic                                skip_report,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tos_pkg::OUT_W-1:0]    offset_horizontal,
	output logic signed [tos_pkg::OUT_W-1:0]    offset_vertical,
	input  logic                                cfg_write,
	input  logic [tos_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tos_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int SW = FRAC_BITS + 4;
	localparam int QW = 2 * SW + 1;

	tos_pkg::cfg_t        cfg_q;
	logic                 q_full;
	logic                 q_empty;
	logic                 q_push;
	logic                 q_pop;
	logic signed [SW-1:0] raw_x;
	logic signed [SW-1:0] raw_y;
	logic                 raw_skip;
	logic [QW-1:0]        q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha_base  <= tos_pkg::ALPHA_BASE_RESET;
			cfg_q.orientation <= tos_pkg::ORIENT_0;
			cfg_q.mirrored    <= 1'b0;
			cfg_q.direction   <= tos_pkg::DIR_NONE;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tos_pkg::REG_ALPHA_BASE:  cfg_q.alpha_base  <= cfg_data;
				tos_pkg::REG_ORIENTATION: cfg_q.orientation <= cfg_data[1:0];
				tos_pkg::REG_MIRRORED:    cfg_q.mirrored    <= cfg_data[0];
				tos_pkg::REG_DIRECTION:   cfg_q.direction   <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	tos_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.box_left   (box_left),
		.box_top    (box_top),
		.box_width  (box_width),
		.box_height (box_height),
		.skip_report(skip_report),
		.direction  (cfg_q.direction),
		.q_full     (q_full),
		.q_push     (q_push),
		.raw_x      (raw_x),
		.raw_y      (raw_y),
		.raw_skip   (raw_skip)
	);

	tos_fifo #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata ({raw_skip, raw_y, raw_x}),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	tos_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_empty          (q_empty),
		.q_raw_x          ($signed(q_rdata[SW-1:0])),
		.q_raw_y          ($signed(q_rdata[2*SW-1:SW])),
		.q_skip           (q_rdata[QW-1]),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.offset_horizontal(offset_horizontal),
		.offset_vertical  (offset_vertical)
	);

endmodule
